/* rtl/set_assoc_lru_cache_sim_top_macros.svh */
// Assertion macros for the cache simulator checker.
`ifndef SET_ASSOC_LRU_CACHE_SIM_TOP_MACROS_SVH
`define SET_ASSOC_LRU_CACHE_SIM_TOP_MACROS_SVH
`define SALC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SALC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* rtl/salc_pkg.sv */
// Shared types and constants for the cache simulator.
package salc_pkg;
  localparam int MAX_SET_BITS_DEF = 6;
  localparam int MAX_WAYS_DEF = 8;
  localparam int SET_BITS_W = 3;
  localparam int WAYS_W = 4;
  localparam int OFF_BITS_W = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 6;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_BITS = 2'd2;
  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_STORE = 2'd1;
  localparam logic [1:0] REQ_MODIFY = 2'd2;
  localparam logic [1:0] REQ_IFETCH = 2'd3;
  localparam logic [31:0] TOTAL_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] address;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  hits_now;
    logic        misses_now;
    logic        evictions_now;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
    logic [31:0] eviction_total;
  } out_word_t;

  // classified request from front to back
  typedef struct packed {
    logic        skip;
    logic        twice;
    logic [11:0] set;
    logic [63:0] tag;
  } cmd_t;
endpackage

/* rtl/set_assoc_lru_cache_sim_top.sv */
// Top level of the set-associative LRU cache simulator.
// Words pass from input accept through a two-entry command queue to the back end, which
// does one lookup for a load or store, two for a modify and none for a fetch, one word at
// a time, each lookup a read-then-update of the per-set memories; the queue takes new words
// while the back end is busy, until full. Synchronous active-low reset clears totals and use
// clock, sets config defaults, then a one-cycle-per-set pass clears valid bits.
module set_assoc_lru_cache_sim_top #(
  parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_DEF,
  parameter int MAX_WAYS = salc_pkg::MAX_WAYS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  salc_pkg::in_word_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output salc_pkg::out_word_t             out_data,
  input  logic                            cfg_we,
  input  logic [salc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [salc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import salc_pkg::*;

  logic [SET_BITS_W-1:0] set_bits_r;
  logic [WAYS_W-1:0] ways_r;
  logic [OFF_BITS_W-1:0] off_bits_r;
  logic q_valid, q_pop;
  cmd_t q_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r <= 3'd4;
      ways_r <= 4'd1;
      off_bits_r <= 6'd4;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SET_BITS: set_bits_r <= cfg_data[SET_BITS_W-1:0];
        CFG_WAYS: ways_r <= cfg_data[WAYS_W-1:0];
        CFG_OFF_BITS: off_bits_r <= cfg_data;
        default: ;
      endcase
    end
  end

  salc_front #(.MAX_SET_BITS(MAX_SET_BITS)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .set_bits(set_bits_r), .off_bits(off_bits_r),
    .q_valid, .q_pop, .q_cmd
  );

  salc_back #(.MAX_SET_BITS(MAX_SET_BITS), .MAX_WAYS(MAX_WAYS)) u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_cmd, .ways_cfg(ways_r),
    .out_valid, .out_stall, .out_data
  );
endmodule

/* rtl/salc_front.sv */
// Front end: accepts words, splits the address and queues commands.
module salc_front #(
  parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  salc_pkg::in_word_t             in_data,
  input  logic [salc_pkg::SET_BITS_W-1:0] set_bits,
  input  logic [salc_pkg::OFF_BITS_W-1:0] off_bits,
  output logic                           q_valid,
  input  logic                           q_pop,
  output salc_pkg::cmd_t                 q_cmd
);
  import salc_pkg::*;

  cmd_t q_r [2];
  logic [1:0] cnt_r;
  logic rd_r, wr_r;
  logic push;
  logic [6:0] sb, bb, tot;
  logic [63:0] shifted, setmask;
  cmd_t c;

  assign in_stall = (cnt_r == 2'd2);
  assign push = in_valid && !in_stall;
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd = q_r[rd_r];

  always_comb begin
    sb = (7'(set_bits) > 7'(MAX_SET_BITS)) ? 7'(MAX_SET_BITS) : 7'(set_bits);
    bb = (7'(off_bits) > 7'd32) ? 7'd32 : 7'(off_bits);
    tot = sb + bb;
    shifted = in_data.address >> bb;
    setmask = (64'd1 << sb) - 64'd1;
    c.skip = (in_data.req_type == REQ_IFETCH);
    c.twice = (in_data.req_type == REQ_MODIFY);
    c.set = 12'(shifted & setmask);
    c.tag = (tot < 7'd64) ? (in_data.address >> tot) : 64'd0;
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_r] <= c;
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r <= 1'b0;
      wr_r <= 1'b0;
    end else begin
      if (push) wr_r <= !wr_r;
      if (q_pop) rd_r <= !rd_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end
endmodule

/* rtl/salc_back.sv */
// Back end: set lookup, LRU replacement and counters.
module salc_back #(
  parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_DEF,
  parameter int MAX_WAYS = salc_pkg::MAX_WAYS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  output logic                        q_pop,
  input  salc_pkg::cmd_t              q_cmd,
  input  logic [salc_pkg::WAYS_W-1:0] ways_cfg,
  output logic                        out_valid,
  input  logic                        out_stall,
  output salc_pkg::out_word_t         out_data
);
  import salc_pkg::*;
  localparam int SETW = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int NSETS = 1 << MAX_SET_BITS;
  localparam int WIW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WCW = $clog2(MAX_WAYS + 1);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_LOOK, S_OUT} st_t;
  st_t st_r;

  logic [MAX_WAYS-1:0] vld_mem [NSETS];
  logic [63:0] tag_mem [NSETS][MAX_WAYS];
  logic [63:0] stp_mem [NSETS][MAX_WAYS];
  logic [63:0] tag_rd_r [MAX_WAYS];
  logic [63:0] stp_rd_r [MAX_WAYS];
  logic [MAX_WAYS-1:0] vrd_r;
  logic [SETW-1:0] clr_r;

  cmd_t cmd_r;
  logic [SETW-1:0] set_idx;
  logic [63:0] clock_r;
  logic [31:0] hc_r, mc_r, ec_r;
  logic [1:0] h_r;
  logic m_r, e_r;
  logic second_r;
  logic [WCW-1:0] ways;

  logic hit;
  logic [WIW-1:0] hit_w, pick;
  logic found_inv;
  logic [WIW-1:0] inv_w, old_w;
  logic [MAX_WAYS-1:0] pick_bit;

  assign set_idx = SETW'(cmd_r.set);
  assign q_pop = (st_r == S_IDLE) && q_valid;
  assign out_valid = (st_r == S_OUT);

  always_comb begin
    if (ways_cfg == '0) ways = WCW'(1);
    else if (32'(ways_cfg) > MAX_WAYS) ways = WCW'(MAX_WAYS);
    else ways = WCW'(ways_cfg);
  end

  always_comb begin
    hit = 1'b0;
    hit_w = '0;
    found_inv = 1'b0;
    inv_w = '0;
    old_w = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (w < int'(ways)) begin
        if (vrd_r[w] && tag_rd_r[w] == cmd_r.tag) begin
          hit = 1'b1;
          hit_w = WIW'(w);
        end
        if (!vrd_r[w]) begin
          found_inv = 1'b1;
          inv_w = WIW'(w);
        end
      end
    end
    for (int w = 1; w < MAX_WAYS; w++)
      if (w < int'(ways) && stp_rd_r[w] < stp_rd_r[old_w]) old_w = WIW'(w);
    pick = hit ? hit_w : (found_inv ? inv_w : old_w);
    pick_bit = MAX_WAYS'(1) << pick;
  end

  always_ff @(posedge clk) begin
    if (st_r == S_CLEAR) vld_mem[clr_r] <= '0;
    if (st_r == S_READ) begin
      for (int w = 0; w < MAX_WAYS; w++) begin
        tag_rd_r[w] <= tag_mem[set_idx][w];
        stp_rd_r[w] <= stp_mem[set_idx][w];
      end
    end
    if (st_r == S_LOOK) begin
      vld_mem[set_idx] <= vrd_r | pick_bit;
      stp_mem[set_idx][pick] <= clock_r;
      if (!hit) tag_mem[set_idx][pick] <= cmd_r.tag;
    end
    if (!rst_n) begin
      st_r <= S_CLEAR;
      clr_r <= '0;
      clock_r <= '0;
      hc_r <= '0;
      mc_r <= '0;
      ec_r <= '0;
      h_r <= '0;
      m_r <= 1'b0;
      e_r <= 1'b0;
      second_r <= 1'b0;
      vrd_r <= '0;
    end else begin
      unique case (st_r)
        S_CLEAR: begin
          clr_r <= clr_r + SETW'(1);
          if (clr_r == SETW'(NSETS - 1)) st_r <= S_IDLE;
        end
        S_IDLE: begin
          if (q_valid) begin
            cmd_r <= q_cmd;
            h_r <= '0;
            m_r <= 1'b0;
            e_r <= 1'b0;
            second_r <= 1'b0;
            st_r <= q_cmd.skip ? S_OUT : S_READ;
          end
        end
        S_READ: begin
          vrd_r <= vld_mem[set_idx];
          st_r <= S_LOOK;
        end
        S_LOOK: begin
          clock_r <= clock_r + 64'd1;
          if (hit) begin
            h_r <= h_r + 2'd1;
            if (hc_r != TOTAL_MAX) hc_r <= hc_r + 32'd1;
          end else begin
            m_r <= 1'b1;
            if (mc_r != TOTAL_MAX) mc_r <= mc_r + 32'd1;
            if (!found_inv) begin
              e_r <= 1'b1;
              if (ec_r != TOTAL_MAX) ec_r <= ec_r + 32'd1;
            end
          end
          if (cmd_r.twice && !second_r) begin
            second_r <= 1'b1;
            st_r <= S_READ;
          end else begin
            st_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall) st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    out_data.hits_now = h_r;
    out_data.misses_now = m_r;
    out_data.evictions_now = e_r;
    out_data.hit_total = hc_r;
    out_data.miss_total = mc_r;
    out_data.eviction_total = ec_r;
  end
endmodule

/* rtl/salc_checker.sv */
// Port-level checker for the cache simulator, bound to the top level.
`include "set_assoc_lru_cache_sim_top_macros.svh"
module salc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input salc_pkg::out_word_t out_data
);
  `SALC_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(out_data))
  `SALC_ASSERT_IMPL(a_one_miss, out_valid, !(out_data.misses_now && out_data.hits_now == 2'd2))
  `SALC_ASSERT_IMPL(a_evict_miss, out_valid && out_data.evictions_now, out_data.misses_now)
  `SALC_ASSERT_NEXT(a_mono, out_valid && !out_stall,
    out_data.hit_total >= $past(out_data.hit_total))
endmodule

bind set_assoc_lru_cache_sim_top salc_checker u_chk (
  .clk, .rst_n, .out_valid, .out_stall, .out_data
);

/* bench/testbench.sv */
// Self-checking bench for the LRU cache simulator: predicts every result word and compares it.
`timescale 1ns / 1ps

module testbench;
  import salc_pkg::*;

  localparam int N_SETS = 1 << MAX_SET_BITS_DEF;
  localparam int N_LINES = N_SETS * MAX_WAYS_DEF;
  localparam int STALL_LIMIT = 20000;

  class cache_scoreboard;
    bit            valid_q[N_LINES];
    logic [63:0]   tag_q[N_LINES];
    logic [63:0]   stamp_q[N_LINES];
    logic [63:0]   use_clk;
    logic [31:0]   hit_cnt, miss_cnt, evict_cnt;
    logic [2:0]    set_bits;
    logic [3:0]    ways;
    logic [5:0]    off_bits;
    out_word_t     pending[$];
    int            mismatches;
    int            checked;

    function void clear();
      foreach (valid_q[k]) valid_q[k] = 0;
      use_clk = '0;
      hit_cnt = '0;
      miss_cnt = '0;
      evict_cnt = '0;
      set_bits = 3'd4;
      ways = 4'd1;
      off_bits = 6'd4;
      mismatches = 0;
      checked = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_SET_BITS: set_bits = val[2:0];
        CFG_WAYS: ways = val[3:0];
        CFG_OFF_BITS: off_bits = val[5:0];
        default: ;
      endcase
    endfunction

    function void probe(int base, int nw, logic [63:0] tg,
                        inout logic [1:0] h, inout logic m, inout logic e);
      int pick;
      bit found;
      pick = 0;
      found = 0;
      for (int w = 0; w < nw; w++) begin
        if (valid_q[base + w] && tag_q[base + w] == tg) begin
          stamp_q[base + w] = use_clk;
          use_clk++;
          h++;
          if (hit_cnt != TOTAL_MAX) hit_cnt++;
          return;
        end
      end
      m = 1'b1;
      if (miss_cnt != TOTAL_MAX) miss_cnt++;
      for (int w = 0; w < nw; w++) begin
        if (!found && !valid_q[base + w]) begin
          pick = w;
          found = 1;
        end
      end
      if (!found) begin
        for (int w = 1; w < nw; w++)
          if (stamp_q[base + w] < stamp_q[base + pick]) pick = w;
        e = 1'b1;
        if (evict_cnt != TOTAL_MAX) evict_cnt++;
      end
      valid_q[base + pick] = 1;
      tag_q[base + pick] = tg;
      stamp_q[base + pick] = use_clk;
      use_clk++;
    endfunction

    function void note_access(in_word_t w);
      int sb, bb, nw, base;
      logic [63:0] set_no, tg;
      out_word_t r;
      sb = (set_bits > MAX_SET_BITS_DEF) ? MAX_SET_BITS_DEF : set_bits;
      bb = (off_bits > 32) ? 32 : off_bits;
      nw = (ways < 1) ? 1 : ((ways > MAX_WAYS_DEF) ? MAX_WAYS_DEF : ways);
      r = '0;
      if (w.req_type != REQ_IFETCH) begin
        set_no = (w.address >> bb) & ((64'd1 << sb) - 64'd1);
        tg = (sb + bb < 64) ? (w.address >> (sb + bb)) : 64'd0;
        base = int'(set_no) * MAX_WAYS_DEF;
        probe(base, nw, tg, r.hits_now, r.misses_now, r.evictions_now);
        if (w.req_type == REQ_MODIFY)
          probe(base, nw, tg, r.hits_now, r.misses_now, r.evictions_now);
      end
      r.hit_total = hit_cnt;
      r.miss_total = miss_cnt;
      r.eviction_total = evict_cnt;
      pending.push_back(r);
    endfunction

    function void check_word(out_word_t got);
      out_word_t exp;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", got);
        return;
      end
      exp = pending.pop_front();
      if (got !== exp) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp h%0d m%0d e%0d %0d/%0d/%0d got h%0d m%0d e%0d %0d/%0d/%0d",
                   exp.hits_now, exp.misses_now, exp.evictions_now, exp.hit_total,
                   exp.miss_total, exp.eviction_total, got.hits_now, got.misses_now,
                   got.evictions_now, got.hit_total, got.miss_total, got.eviction_total);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  out_word_t out_data;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_SET_BITS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  cache_scoreboard sb = new();
  int idle_pct = 30;
  bit hold_off = 0;
  int quiet_cycles = 0;
  int sent = 0;

  set_assoc_lru_cache_sim_top uut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_access(in_data);
    if (rst_n && out_valid && !out_stall) sb.check_word(out_data);
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("timeout waiting for handshake");
      $display("testbench: done, errors");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= hold_off || ($urandom_range(99) < idle_pct);
  end

  task automatic send(logic [1:0] kind, logic [63:0] addr);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_data <= '{req_type: kind, address: addr};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    sb.write_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic configure(int s, int w, int o);
    drain();
    set_reg(CFG_SET_BITS, CFG_DATA_W'(s));
    set_reg(CFG_WAYS, CFG_DATA_W'(w));
    set_reg(CFG_OFF_BITS, CFG_DATA_W'(o));
    cfg_we <= 0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic random_phase(int count, int o);
    logic [63:0] pool[8];
    logic [63:0] a;
    foreach (pool[k]) pool[k] = rand64();
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(9))
        0, 1: a = rand64();
        default: begin
          a = pool[$urandom_range(7)];
          a = a ^ (64'($urandom_range(63)) << (o > 32 ? 32 : o));
          a = a ^ 64'($urandom_range(15));
        end
      endcase
      send(2'($urandom_range(3)), a);
    end
  endtask

  initial begin
    sb.clear();
    repeat (10) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    send(REQ_LOAD, 64'h0);
    send(REQ_LOAD, 64'h0);
    send(REQ_STORE, 64'hFFFF_FFFF_FFFF_FFFF);
    send(REQ_MODIFY, 64'h1234_5678_9ABC_DEF0);
    send(REQ_IFETCH, 64'h0);
    send(REQ_STORE, 64'h100);
    send(REQ_LOAD, 64'h0);
    configure(7, 0, 63);
    send(REQ_LOAD, 64'hFFFF_FFFF_0000_0000);
    send(REQ_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF);
    configure(6, 15, 32);
    send(REQ_LOAD, 64'h0);
    send(REQ_LOAD, 64'hAAAA_AAAA_5555_5555);
    for (int k = 0; k < 10; k++) send(REQ_STORE, 64'(k) << 38);
    send(REQ_MODIFY, 64'h0);
    configure(0, 1, 0);
    send(REQ_LOAD, 64'h5555_5555_AAAA_AAAA);
    send(REQ_IFETCH, 64'hFFFF_FFFF_FFFF_FFFF);

    configure(4, 4, 4);
    idle_pct = 0;
    random_phase(300, 4);
    idle_pct = 30;
    configure(2, 8, 6);
    random_phase(300, 6);
    configure(0, 2, 0);
    random_phase(250, 0);
    configure(6, 1, 32);
    random_phase(250, 32);
    configure(3, 3, 5);
    fork
      begin
        hold_off = 1;
        repeat (200) @(negedge clk);
        hold_off = 0;
      end
      random_phase(300, 5);
    join
    drain();
    configure(5, 8, 1);
    random_phase(230, 1);

    drain();
    $display("covered %0d accesses, %0d result words; %0d hits, %0d misses, %0d evictions",
             sent, sb.checked, sb.hit_cnt, sb.miss_cnt, sb.evict_cnt);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("testbench: done, errors");
    end
    $finish;
  end
endmodule
